@@ rtl/ascending_sorted_priority_queue_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASCENDING_SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define ASCENDING_SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue check failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Types, constants and helpers shared by the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // store geometry
    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // fixed port field widths
    localparam int VALUE_W = 32;
    localparam int OCC_W   = 4;

    // occupancy value reported when the store is full
    localparam logic [CNT_W-1:0]       DEPTH_CNT  = CNT_W'(DEPTH);
    localparam logic [CNT_W+OCC_W-1:0] DEPTH_WIDE = (CNT_W + OCC_W)'(DEPTH);
    localparam logic [OCC_W-1:0]       OCC_FULL   = DEPTH_WIDE[OCC_W-1:0];

    typedef enum logic
    {
        FUNC_INSERT = 1'b0,
        FUNC_DELETE = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // operation broadcast to every cell
    typedef struct packed
    {
        logic                         ins;
        logic                         del;
        logic signed [DATA_WIDTH-1:0] val;
    } spq_ctrl_t;

    // what a cell shows its neighbors
    typedef struct packed
    {
        logic signed [DATA_WIDTH-1:0] data;
        logic                         occ;
        logic                         gt;
    } spq_link_t;

    // port value into store width, zero extended or truncated
    function automatic logic [DATA_WIDTH-1:0] to_data(input logic [VALUE_W-1:0] v);
        logic [DATA_WIDTH+VALUE_W-1:0] wide;
        wide = {{DATA_WIDTH{1'b0}}, v};
        return wide[DATA_WIDTH-1:0];
    endfunction

    // store entry onto the port, zero extended or truncated
    function automatic logic [VALUE_W-1:0] to_value(input logic [DATA_WIDTH-1:0] d);
        logic [DATA_WIDTH+VALUE_W-1:0] wide;
        wide = {{VALUE_W{1'b0}}, d};
        return wide[VALUE_W-1:0];
    endfunction

    // count onto the occupancy field, modulo its width
    function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] c);
        logic [CNT_W+OCC_W-1:0] wide;
        wide = {{OCC_W{1'b0}}, c};
        return wide[OCC_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One position of the sorted store: compares against the broadcast value and
// takes the new value or its left neighbor's data on insert, or its right neighbor's data on delete.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire spq_ctrl_t ctrl,
    input  wire spq_link_t left,
    input  wire spq_link_t right,
    output spq_link_t      own
);

    logic signed [DATA_WIDTH-1:0] data_reg;
    logic signed [DATA_WIDTH-1:0] data_next;
    logic                         occ_reg;
    logic                         occ_next;
    logic                         gt;

    // stored entry is strictly larger than the new value
    assign gt = occ_reg && ($signed(data_reg) > $signed(ctrl.val));

    // insert shifts up from the first larger entry, delete shifts down
    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (ctrl.ins)
        begin
            if (gt || (!occ_reg && left.occ))
            begin
                data_next = left.gt ? left.data : ctrl.val;
                occ_next  = 1'b1;
            end
        end
        else if (ctrl.del)
        begin
            data_next = right.data;
            occ_next  = right.occ;
        end
    end

    // occupied flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign own.data = data_reg;
    assign own.occ  = occ_reg;
    assign own.gt   = gt;

endmodule

`default_nettype wire

@@ rtl/ascending_sorted_priority_queue_top.sv @@
// A result is registered and appears in the cycle after the request transfer.
// Throughput: one operation per cycle unless requests stall; every cell compares and shifts at once.
// Requests stall only while a result is held and the result side stalls.
// Reset clears the entry count and all occupied flags; entry payloads are
// not reset and never show before being written.
// ----------------------------------------------------------------------------
// ascending_sorted_priority_queue_top
// Bounded min-first priority queue built as a row of sorted cells.
// ----------------------------------------------------------------------------
`default_nettype none

module ascending_sorted_priority_queue_top
    import spq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic                func,
    input  wire logic [VALUE_W-1:0]  value,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output logic [1:0]               status,
    output logic [VALUE_W-1:0]       removed,
    output logic [OCC_W-1:0]         occupancy
);

    spq_ctrl_t          ctrl;
    spq_link_t          links [DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    status_t            status_reg;
    status_t            status_next;
    logic [VALUE_W-1:0] removed_reg;
    logic [VALUE_W-1:0] removed_next;
    logic [OCC_W-1:0]   occ_reg;
    logic               xfer;
    logic               is_full;
    logic               is_empty;

    // request transfer and queue state
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign xfer      = req_valid && !req_stall;
    assign is_full   = (count_reg == DEPTH_CNT);
    assign is_empty  = (count_reg == '0);

    // broadcast operation
    assign ctrl.ins = xfer && (func_t'(func) == FUNC_INSERT) && !is_full;
    assign ctrl.del = xfer && (func_t'(func) == FUNC_DELETE) && !is_empty;
    assign ctrl.val = to_data(value);

    // row of cells, each linked to both neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_link_t left;
        spq_link_t right;

        if (i == 0)
        begin : g_head
            assign left = '{data: '0, occ: 1'b1, gt: 1'b0};
        end
        else
        begin : g_body
            assign left = links[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right = '{data: '0, occ: 1'b0, gt: 1'b0};
        end
        else
        begin : g_mid
            assign right = links[i+1];
        end

        spq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left),
            .right (right),
            .own   (links[i])
        );
    end

    // count update and result fields
    always_comb
    begin
        count_next   = count_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.del)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        if (xfer)
        begin
            removed_next = '0;
            case (func_t'(func))
                FUNC_INSERT:
                begin
                    status_next = is_full ? STATUS_FULL : STATUS_DONE;
                end
                FUNC_DELETE:
                begin
                    status_next = is_empty ? STATUS_EMPTY : STATUS_DONE;
                    if (!is_empty)
                    begin
                        removed_next = to_value(links[0].data);
                    end
                end
                default:
                begin
                    status_next = STATUS_DONE;
                end
            endcase
        end

        if (xfer)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        if (xfer)
        begin
            occ_reg <= to_occ(count_next);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign removed   = removed_reg;
    assign occupancy = occ_reg;

endmodule

`default_nettype wire

@@ rtl/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascending_sorted_priority_queue_top_defines.svh"

module spq_checker
    import spq_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_stall,
    input wire logic               func,
    input wire logic [VALUE_W-1:0] value,
    input wire logic               rsp_valid,
    input wire logic               rsp_stall,
    input wire logic [1:0]         status,
    input wire logic [VALUE_W-1:0] removed,
    input wire logic [OCC_W-1:0]   occupancy
);

    // a transfer always yields a result in the next cycle
    `SPQ_ASSERT_NEXT(a_xfer_gives_result, req_valid && !req_stall, rsp_valid)

    // requests stall only behind a held result
    `SPQ_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)

    // a rejected insert reports a full queue and nothing removed
    `SPQ_ASSERT_NOW(a_full_result, rsp_valid && status == STATUS_FULL,
                    occupancy == OCC_FULL && removed == '0)

    // a delete on empty reports zero entries and nothing removed
    `SPQ_ASSERT_NOW(a_empty_result, rsp_valid && status == STATUS_EMPTY,
                    occupancy == '0 && removed == '0)

endmodule

bind ascending_sorted_priority_queue_top spq_checker u_spq_checker (.*);

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the ascending sorted priority queue. A driver offers insert
// and delete requests in bursts from a backlog of planned operations. A
// monitor checks each result against a software copy of the sorted store
// while the receiver stalls in phases, including at least one long hold-off.
// ----------------------------------------------------------------------------

module tb;
    import spq_pkg::*;

    localparam int RANDOM_OPS  = 1350;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYC  = 8;

    typedef enum logic [1:0]
    {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_HOLD
    } rx_mode_t;

    typedef struct
    {
        func_t              op;
        logic [VALUE_W-1:0] operand;
        bit                 wait_drain;
    } queue_op_t;

    typedef struct
    {
        status_t            status;
        logic [VALUE_W-1:0] removed;
        logic [OCC_W-1:0]   occupancy;
    } queue_result_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic               func      = FUNC_INSERT;
    logic [VALUE_W-1:0] value     = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [1:0]         status;
    logic [VALUE_W-1:0] removed;
    logic [OCC_W-1:0]   occupancy;

    ascending_sorted_priority_queue_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .removed   (removed),
        .occupancy (occupancy)
    );

    // software copy of the sorted store
    logic signed [VALUE_W-1:0] sorted_vals [DEPTH];
    int unsigned               sorted_len = 0;

    queue_op_t     op_backlog[$];
    queue_result_t expected_results[$];
    bit            drain_next   = 1'b0;
    int            issued_cnt   = 0;
    int            received_cnt = 0;
    int            fail_cnt     = 0;
    int            cycle_cnt    = 0;

    int            burst_left = 1;
    int            gap_left   = 0;
    rx_mode_t      rx_mode    = RX_FREE;
    int            rx_left    = 20;
    int            rx_phase   = 0;

    // apply one operation to the sorted store, return what the block reports
    function automatic queue_result_t predict_queue_op(func_t op,
                                                       logic [VALUE_W-1:0] operand);
        queue_result_t res;
        int            pos;
        res.status  = STATUS_DONE;
        res.removed = '0;
        if (op == FUNC_INSERT)
        begin
            if (sorted_len >= DEPTH)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                // new entry goes behind all equal ones
                pos = sorted_len;
                while (pos > 0 && sorted_vals[pos-1] > $signed(operand))
                begin
                    sorted_vals[pos] = sorted_vals[pos-1];
                    pos--;
                end
                sorted_vals[pos] = operand;
                sorted_len++;
            end
        end
        else
        begin
            if (sorted_len == 0)
            begin
                res.status = STATUS_EMPTY;
            end
            else
            begin
                res.removed = sorted_vals[0];
                for (pos = 1; pos < sorted_len; pos++)
                    sorted_vals[pos-1] = sorted_vals[pos];
                sorted_len--;
            end
        end
        res.occupancy = OCC_W'(sorted_len);
        return res;
    endfunction

    // operand mix: wide random, tight clusters for ties, extremes, single bits
    function automatic logic [VALUE_W-1:0] pick_operand();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = VALUE_W'($signed($urandom_range(0, 8)) - 4);
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       v = {1'b1, {(VALUE_W-1){1'b0}}};
                    1:       v = {1'b0, {(VALUE_W-1){1'b1}}};
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            7:       v = {1'b1, (VALUE_W-1)'($urandom_range(0, 3))};
            8:       v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
            default: v = ~(VALUE_W'(1) << $urandom_range(0, VALUE_W - 1));
        endcase
        return v;
    endfunction

    task automatic plan_op(func_t op, logic [VALUE_W-1:0] operand);
        queue_op_t item;
        item.op         = op;
        item.operand    = operand;
        item.wait_drain = drain_next;
        drain_next      = 1'b0;
        op_backlog.push_back(item);
    endtask

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_results.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    // request driver: bursts from the backlog, optional drain before an item
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        queue_op_t     nxt;
        queue_result_t res;
        logic          took;
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            took = req_valid && !req_stall;
            if (took)
            begin
                res = predict_queue_op(func_t'(func), value);
                expected_results.push_back(res);
                issued_cnt <= issued_cnt + 1;
            end
            if (req_valid && !took)
            begin
                // stalled transfer holds its payload
            end
            else if (gap_left != 0)
            begin
                gap_left  <= gap_left - 1;
                req_valid <= 1'b0;
            end
            else if (op_backlog.size() == 0)
            begin
                req_valid <= 1'b0;
            end
            else if (op_backlog[0].wait_drain && (took || issued_cnt != received_cnt))
            begin
                req_valid <= 1'b0;
            end
            else
            begin
                nxt       = op_backlog.pop_front();
                func      <= nxt.op;
                value     <= nxt.operand;
                req_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // result stall pattern in phases; one early phase is a long hold-off
    always @(posedge clk or negedge rst_n)
    begin : rsp_pacer
        rx_mode_t mode;
        logic     hold;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rx_mode   <= RX_FREE;
            rx_left   <= 20;
            rx_phase  <= 0;
        end
        else
        begin
            mode = rx_mode;
            if (rx_left == 0)
            begin
                if (rx_phase == 4 || $urandom_range(0, 11) == 0)
                begin
                    mode    = RX_HOLD;
                    rx_left <= $urandom_range(150, 250);
                end
                else
                begin
                    mode    = rx_mode_t'($urandom_range(0, 2));
                    rx_left <= $urandom_range(10, 120);
                end
                rx_phase <= rx_phase + 1;
            end
            else
            begin
                rx_left <= rx_left - 1;
            end
            rx_mode <= mode;
            case (mode)
                RX_FREE:  hold = 1'b0;
                RX_LIGHT: hold = ($urandom_range(0, 3) == 0);
                RX_HEAVY: hold = ($urandom_range(0, 3) != 0);
                default:  hold = 1'b1;
            endcase
            rsp_stall <= hold;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : rsp_checker
        queue_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            received_cnt <= received_cnt + 1;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d removed %0d occupancy %0d",
                         $time, status, $signed(removed), occupancy);
                fail_cnt++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, status);
                    fail_cnt++;
                end
                if (removed !== want.removed)
                begin
                    $display("%0t: removed expected %0d got %0d",
                             $time, $signed(want.removed), $signed(removed));
                    fail_cnt++;
                end
                if (occupancy !== want.occupancy)
                begin
                    $display("%0t: occupancy expected %0d got %0d",
                             $time, want.occupancy, occupancy);
                    fail_cnt++;
                end
            end
        end
    end

    // stimulus plan, reset and end of run
    initial
    begin
        int planned;
        int seg_no;
        int n;
        int bias;

        // directed: empty delete, extremes, ties, overflow, full drain
        plan_op(FUNC_DELETE, 32'h1234_5678);
        plan_op(FUNC_INSERT, 32'h7fff_ffff);
        plan_op(FUNC_INSERT, 32'h8000_0000);
        plan_op(FUNC_INSERT, 32'h0000_0000);
        plan_op(FUNC_INSERT, 32'hffff_ffff);
        plan_op(FUNC_INSERT, 32'h0000_0005);
        plan_op(FUNC_INSERT, 32'h0000_0005);
        plan_op(FUNC_INSERT, 32'h0000_0001);
        plan_op(FUNC_INSERT, 32'h8000_0000);
        plan_op(FUNC_INSERT, 32'h0000_0003);
        plan_op(FUNC_INSERT, 32'h8000_0000);
        for (int k = 0; k < DEPTH; k++)
            plan_op(FUNC_DELETE, $urandom);
        plan_op(FUNC_DELETE, 32'hffff_ffff);
        drain_next = 1'b1;
        plan_op(FUNC_INSERT, 32'h7fff_ffff);
        plan_op(FUNC_DELETE, 32'h0000_0000);

        // random: fill/drain runs, biased runs and short mixed runs
        planned = 0;
        seg_no  = 0;
        while (planned < RANDOM_OPS)
        begin
            if (seg_no % 12 == 11)
                drain_next = 1'b1;
            case ($urandom_range(0, 2))
                0:
                begin
                    n = $urandom_range(DEPTH - 3, DEPTH + 2);
                    for (int k = 0; k < n; k++)
                        plan_op(FUNC_INSERT, pick_operand());
                    planned += n;
                    n = $urandom_range(DEPTH - 2, DEPTH + 3);
                    for (int k = 0; k < n; k++)
                        plan_op(FUNC_DELETE, $urandom);
                    planned += n;
                end
                1:
                begin
                    bias = $urandom_range(1, 3);
                    n    = $urandom_range(10, 40);
                    for (int k = 0; k < n; k++)
                    begin
                        if ($urandom_range(0, 3) < bias)
                            plan_op(FUNC_INSERT, pick_operand());
                        else
                            plan_op(FUNC_DELETE, $urandom);
                    end
                    planned += n;
                end
                default:
                begin
                    n = $urandom_range(4, 20);
                    for (int k = 0; k < n; k++)
                        plan_op(func_t'($urandom_range(0, 1)), pick_operand());
                    planned += n;
                end
            endcase
            seg_no++;
        end

        // hold reset, then release it after a rising clock edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // sample between edges so every clocked update has settled
        do
        begin
            @(negedge clk);
        end
        while (op_backlog.size() != 0 || req_valid || issued_cnt != received_cnt);
        repeat (SETTLE_CYC) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/ascending_sorted_priority_queue_top.sv
rtl/spq_checker.sv
bench/tb.sv
